// ===== rtl/core/pidaw_pkg.sv =====
// Shared types, codes and arithmetic helpers of the PID controller with anti-windup.
package pidaw_pkg;

	localparam int unsigned DataW = 32;
	localparam int unsigned StepW = 31;
	localparam int unsigned PcW   = 3;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned ProdW = 2 * DataW;
	localparam int unsigned AccW  = DataW + 2;

	localparam logic signed [DataW-1:0] SMax = {1'b0, {(DataW-1){1'b1}}};
	localparam logic signed [DataW-1:0] SMin = {1'b1, {(DataW-1){1'b0}}};

	// Configuration register indexes.
	typedef enum logic [IdxW-1:0] {
		REG_KP   = 3'd0,
		REG_KI   = 3'd1,
		REG_KD   = 3'd2,
		REG_TS   = 3'd3,
		REG_ILO  = 3'd4,
		REG_IHI  = 3'd5,
		REG_OLO  = 3'd6,
		REG_OHI  = 3'd7
	} reg_idx_t;

	// Datapath operation of one microcode step.
	typedef enum logic [2:0] {
		ALU_NOP,
		ALU_ERR,
		ALU_DIFF,
		ALU_INTEG,
		ALU_DTERM,
		ALU_ACC,
		ALU_OUT,
		ALU_CLR
	} alu_op_t;

	// Operand pair of the shared multiplier.
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_ERR_TS,
		MUL_DIFF_KD,
		MUL_KP_ERR,
		MUL_KI_INT
	} mul_sel_t;

	// One word of the control store.
	typedef struct packed {
		alu_op_t  alu;
		mul_sel_t mul;
		logic     br_clr;
		logic     last;
	} ucode_t;

	// Control handed from the sequencer to the datapath each cycle.
	typedef struct packed {
		logic     exec;
		alu_op_t  alu;
		mul_sel_t mul;
	} dp_ctrl_t;

	// Saturate a 33-bit signed sum to 32 bits.
	function automatic logic signed [DataW-1:0] sat33(input logic signed [DataW:0] v);
		logic signed [DataW-1:0] r;
		if (v[DataW] != v[DataW-1]) begin
			r = v[DataW] ? SMin : SMax;
		end else begin
			r = v[DataW-1:0];
		end
		return r;
	endfunction

	// Q16.16 product: arithmetic shift right by 16, then saturate to 32 bits.
	function automatic logic signed [DataW-1:0] qsat(input logic signed [ProdW-1:0] p);
		logic signed [ProdW-17:0] s;
		logic signed [DataW-1:0]  r;
		s = p[ProdW-1:16];
		if (s > $signed({{(ProdW-16-DataW){1'b0}}, SMax})) begin
			r = SMax;
		end else if (s < $signed({{(ProdW-16-DataW){1'b1}}, SMin})) begin
			r = SMin;
		end else begin
			r = s[DataW-1:0];
		end
		return r;
	endfunction

	// Clamp to the lower limit first, then to the upper one.
	function automatic logic signed [DataW-1:0] clamp34(input logic signed [AccW-1:0] v,
			input logic signed [DataW-1:0] lo, input logic signed [DataW-1:0] hi);
		logic signed [AccW-1:0] r;
		r = v;
		if (r < AccW'(lo)) begin
			r = AccW'(lo);
		end
		if (r > AccW'(hi)) begin
			r = AccW'(hi);
		end
		return r[DataW-1:0];
	endfunction

endpackage

// ===== rtl/core/pidaw_sequencer.sv =====
// Microcode sequencer: step counter, control store and clear branch.
module pidaw_sequencer
	import pidaw_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     op_clr,
	input  logic     out_free,
	output logic     busy,
	output dp_ctrl_t ctrl
);

	localparam logic [PcW-1:0] PcClr = PcW'(7);

	logic           busy_q;
	logic [PcW-1:0] pc_q;
	ucode_t         uw;
	logic           stall;

	// Control store: compute runs steps 0..6, a clear branches to step 7.
	function automatic ucode_t ucode(input logic [PcW-1:0] pc);
		ucode_t w;
		unique case (pc)
			3'd0: w = '{alu: ALU_ERR,   mul: MUL_NONE,    br_clr: 1'b1, last: 1'b0};
			3'd1: w = '{alu: ALU_DIFF,  mul: MUL_ERR_TS,  br_clr: 1'b0, last: 1'b0};
			3'd2: w = '{alu: ALU_INTEG, mul: MUL_DIFF_KD, br_clr: 1'b0, last: 1'b0};
			3'd3: w = '{alu: ALU_DTERM, mul: MUL_KP_ERR,  br_clr: 1'b0, last: 1'b0};
			3'd4: w = '{alu: ALU_ACC,   mul: MUL_KI_INT,  br_clr: 1'b0, last: 1'b0};
			3'd5: w = '{alu: ALU_ACC,   mul: MUL_NONE,    br_clr: 1'b0, last: 1'b0};
			3'd6: w = '{alu: ALU_OUT,   mul: MUL_NONE,    br_clr: 1'b0, last: 1'b1};
			3'd7: w = '{alu: ALU_CLR,   mul: MUL_NONE,    br_clr: 1'b0, last: 1'b1};
		endcase
		return w;
	endfunction

	// Fetch the current word; the output step waits for a free result register.
	always_comb begin
		uw        = ucode(pc_q);
		stall     = (uw.alu == ALU_OUT) && !out_free;
		ctrl.exec = busy_q && !stall;
		ctrl.alu  = uw.alu;
		ctrl.mul  = uw.mul;
	end

	assign busy = busy_q;

	// Step counter with the clear branch and end of program.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				pc_q   <= '0;
			end
		end else if (ctrl.exec) begin
			if (uw.br_clr && op_clr) begin
				pc_q <= PcClr;
			end else if (uw.last) begin
				busy_q <= 1'b0;
				pc_q   <= '0;
			end else begin
				pc_q <= pc_q + 1'b1;
			end
		end
	end

	// The counter rests at the first step while idle.
	a_idle_pc: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> pc_q == '0) else $error("step counter not parked while idle");

	// Only the output step may hold the program.
	a_stall_out: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !ctrl.exec |-> uw.alu == ALU_OUT) else $error("stall outside output step");

	// The program ends only after a last step ran.
	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(uw.last && ctrl.exec)) else $error("program ended early");

endmodule

// ===== rtl/core/pidaw_datapath.sv =====
// Datapath: configuration registers, controller state, shared multiplier and accumulator.
module pidaw_datapath
	import pidaw_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_ctrl_t                ctrl,
	input  logic signed [DataW-1:0] setpoint,
	input  logic signed [DataW-1:0] measured,
	input  logic                    cfg_we,
	input  logic [IdxW-1:0]         cfg_index,
	input  logic [DataW-1:0]        cfg_data,
	output logic signed [DataW-1:0] drive
);

	logic signed [DataW-1:0] kp_q, ki_q, kd_q;
	logic [StepW-1:0]        ts_q;
	logic signed [DataW-1:0] ilo_q, ihi_q, olo_q, ohi_q;
	logic signed [DataW-1:0] integ_q, last_q;
	logic                    have_q;
	logic signed [DataW-1:0] err_q, diff_q;
	logic signed [ProdW-1:0] prod_q;
	logic signed [AccW-1:0]  acc_q;

	logic signed [DataW-1:0] mul_a, mul_b;
	logic signed [DataW-1:0] qterm;
	reg_idx_t                widx;

	assign widx  = reg_idx_t'(cfg_index);
	assign qterm = qsat(prod_q);
	assign drive = clamp34(acc_q, olo_q, ohi_q);

	// Operand selection for the multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.mul)
			MUL_ERR_TS: begin
				mul_a = err_q;
				mul_b = $signed({1'b0, ts_q});
			end
			MUL_DIFF_KD: begin
				mul_a = diff_q;
				mul_b = kd_q;
			end
			MUL_KP_ERR: begin
				mul_a = kp_q;
				mul_b = err_q;
			end
			MUL_KI_INT: begin
				mul_a = ki_q;
				mul_b = integ_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Product register of the shared multiplier.
	always_ff @(posedge clk) begin
		if (ctrl.exec && ctrl.mul != MUL_NONE) begin
			prod_q <= mul_a * mul_b;
		end
	end

	// Working registers of one compute item.
	always_ff @(posedge clk) begin
		if (ctrl.exec) begin
			unique case (ctrl.alu)
				ALU_ERR:   err_q  <= sat33((DataW+1)'(setpoint) - (DataW+1)'(measured));
				ALU_DIFF:  diff_q <= sat33((DataW+1)'(err_q) - (DataW+1)'(last_q));
				ALU_DTERM: acc_q  <= have_q ? AccW'(qterm) : '0;
				ALU_ACC:   acc_q  <= acc_q + AccW'(qterm);
				default: begin
				end
			endcase
		end
	end

	// Configuration registers and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_q    <= DataW'(65536);
			ki_q    <= '0;
			kd_q    <= '0;
			ts_q    <= StepW'(655);
			ilo_q   <= SMin;
			ihi_q   <= SMax;
			olo_q   <= SMin;
			ohi_q   <= SMax;
			integ_q <= '0;
			last_q  <= '0;
			have_q  <= 1'b0;
		end else if (cfg_we) begin
			unique case (widx)
				REG_KP: kp_q <= cfg_data;
				REG_KI: ki_q <= cfg_data;
				REG_KD: kd_q <= cfg_data;
				REG_TS: begin
					if (cfg_data[StepW-1:0] != '0) begin
						ts_q <= cfg_data[StepW-1:0];
					end
				end
				REG_ILO: begin
					ilo_q   <= cfg_data;
					integ_q <= clamp34(AccW'(integ_q), cfg_data, ihi_q);
				end
				REG_IHI: begin
					ihi_q   <= cfg_data;
					integ_q <= clamp34(AccW'(integ_q), ilo_q, cfg_data);
				end
				REG_OLO: olo_q <= cfg_data;
				REG_OHI: ohi_q <= cfg_data;
			endcase
		end else if (ctrl.exec) begin
			unique case (ctrl.alu)
				ALU_DIFF:  last_q  <= err_q;
				ALU_INTEG: integ_q <= clamp34(AccW'(integ_q) + AccW'(qterm), ilo_q, ihi_q);
				ALU_DTERM: have_q  <= 1'b1;
				ALU_CLR: begin
					integ_q <= '0;
					last_q  <= '0;
					have_q  <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	// With ordered limits, an integration step leaves the integral inside them.
	a_integ_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.exec && ctrl.alu == ALU_INTEG && !cfg_we && ilo_q <= ihi_q
		|=> integ_q >= ilo_q && integ_q <= ihi_q) else $error("integral outside its limits");

endmodule

// ===== rtl/core/pid_controller_anti_windup_unit.sv =====
// Top level of the PID controller with integral clamp anti-windup.
//
//   Channel  | Direction | Handshake          | Contents
//   s_*      | in        | s_tvalid, s_tready | tdata: setpoint, measured; tuser: operation
//   m_*      | out       | m_tvalid, m_tready | tdata: drive
//   cfg_*    | in        | cfg_we             | cfg_index, cfg_data
//
// A compute request runs a seven-step microprogram over one shared 32x32 multiplier;
// a clear request is accepted and then runs two steps, the first step and the clear step.
// The drive value is loaded into the result register by the output step, the last of the seven.
// The next request is taken once the program ends, even while a result still waits.
// The output step waits while the result register is full and not being drained.
// arst_n resets the configuration to its defaults and zeroes the controller state.
module pid_controller_anti_windup_unit
	import pidaw_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [63:0]       s_tdata,   // [31:0] setpoint, [63:32] measured
	input  logic              s_tuser,   // [0] operation: 0 compute, 1 clear
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [DataW-1:0]  m_tdata,   // [31:0] drive
	input  logic              cfg_we,
	input  logic [IdxW-1:0]   cfg_index,
	input  logic [DataW-1:0]  cfg_data
);

	logic                    busy;
	dp_ctrl_t                ctrl;
	logic                    accept;
	logic                    out_free;
	logic                    out_load;
	logic signed [DataW-1:0] drive;

	logic signed [DataW-1:0] sp_q, meas_q;
	logic                    clr_q;
	logic                    m_valid_q;
	logic [DataW-1:0]        m_data_q;

	assign s_tready = !busy;
	assign accept   = s_tvalid && !busy;
	assign out_free = !m_valid_q || m_tready;
	assign out_load = ctrl.exec && ctrl.alu == ALU_OUT;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			sp_q   <= s_tdata[DataW-1:0];
			meas_q <= s_tdata[2*DataW-1:DataW];
			clr_q  <= s_tuser;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= drive;
		end
	end

	pidaw_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.op_clr   (clr_q),
		.out_free (out_free),
		.busy     (busy),
		.ctrl     (ctrl)
	);

	pidaw_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctrl      (ctrl),
		.setpoint  (sp_q),
		.measured  (meas_q),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.drive     (drive)
	);

	// A new result appears only from the output step of the program.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(out_load)) else $error("result without output step");

endmodule
